// ===== rtl/core/keyword_line_and_word_matcher_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the keyword line and word matcher
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_LINE_AND_WORD_MATCHER_ASSERT_SVH
`define KEYWORD_LINE_AND_WORD_MATCHER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define KWM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kwm assertion failed");

// next-cycle implication
`define KWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kwm assertion failed");

`else

`define KWM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define KWM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/kwm_pkg.sv =====
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared constants, codes and types of the keyword line and word matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kwm_pkg;

  localparam int KEY_MAX_DEF = 32;

  localparam int CMD_W    = 2;
  localparam int KIDX_W   = 5;
  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 8;
  localparam int KLEN_W   = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 6;

  // request commands
  localparam logic [CMD_W-1:0] CMD_KEY  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TEXT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EOL  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEYLEN = 2'd1;

  localparam logic MODE_LINE = 1'b0;
  localparam logic MODE_WORD = 1'b1;

  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_WORD = 1'b1;

  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;

  localparam logic [1:0] SKIP_SAT = 2'd2;
  localparam logic [CNT_W-1:0] CNT_SAT = 8'hFF;

  typedef struct packed {
    logic             valid;
    logic             matched;
    logic             kind;
    logic [CNT_W-1:0] length;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/kwm_key_store.sv =====
// ----------------------------------------------------------------------------
// kwm_key_store
// Key byte registers with a parallel compare of every position to one byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kwm_key_store
  import kwm_pkg::*;
#(
  parameter int KEY_MAX = KEY_MAX_DEF,
  localparam int IDX_W = $clog2(KEY_MAX)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [IDX_W-1:0]  wr_addr,
  input  wire logic [BYTE_W-1:0] wr_data,
  input  wire logic [BYTE_W-1:0] cmp_byte,
  output      logic [KEY_MAX-1:0] eq
);

  logic [BYTE_W-1:0] key_r [KEY_MAX];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_r[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    for (int i = 0; i < KEY_MAX; i++) begin
      eq[i] = (key_r[i] == cmp_byte);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/kwm_matcher.sv =====
// ----------------------------------------------------------------------------
// kwm_matcher
// Line and word progress registers and the result of each finished unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kwm_matcher
  import kwm_pkg::*;
#(
  parameter int KEY_MAX = KEY_MAX_DEF,
  localparam int IDX_W = $clog2(KEY_MAX),
  localparam int LEN_W = $clog2(KEY_MAX + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire logic               clear,
  input  wire logic [CMD_W-1:0]   cmd,
  input  wire logic [BYTE_W-1:0]  data_byte,
  input  wire logic [KEY_MAX-1:0] eq,
  input  wire logic               mode,
  input  wire logic [LEN_W-1:0]   eff_len,
  input  wire logic [KEY_MAX-1:0] len_mask,
  input  wire logic [KEY_MAX-1:0] len_top,
  output      res_t               res
);

  logic [KEY_MAX-1:0] pmv_r,   pmv_nxt;
  logic               found_r, found_nxt;
  logic [LEN_W-1:0]   wpos_r,  wpos_nxt;
  logic [1:0]         skip_r,  skip_nxt;
  logic [CNT_W-1:0]   cnt_r,   cnt_nxt;

  logic [CNT_W-1:0] cnt_inc;
  logic             is_sep;

  assign cnt_inc = (cnt_r == CNT_SAT) ? cnt_r : cnt_r + CNT_W'(1);
  assign is_sep  = (data_byte == CH_SPACE) || (data_byte == CH_NEWLINE);

  always_comb begin
    pmv_nxt   = pmv_r;
    found_nxt = found_r;
    wpos_nxt  = wpos_r;
    skip_nxt  = skip_r;
    cnt_nxt   = cnt_r;
    res       = '0;
    if (step) begin
      unique case (cmd)
        CMD_TEXT: begin
          if (mode == MODE_LINE) begin
            pmv_nxt = {pmv_r[KEY_MAX-2:0], 1'b1} & eq & len_mask;
            if (|(pmv_nxt & len_top)) begin
              found_nxt = 1'b1;
            end
            cnt_nxt = cnt_inc;
          end else if (is_sep) begin
            if (cnt_r != '0) begin
              res.valid   = 1'b1;
              res.matched = (wpos_r == eff_len) && (skip_r < SKIP_SAT);
              res.kind    = KIND_WORD;
              res.length  = cnt_r;
              wpos_nxt    = '0;
              skip_nxt    = '0;
              cnt_nxt     = '0;
            end
          end else begin
            // greedy: take the next key byte if it fits, else spend a skip
            if ((wpos_r < eff_len) && eq[wpos_r[IDX_W-1:0]]) begin
              wpos_nxt = wpos_r + LEN_W'(1);
            end else if (skip_r != SKIP_SAT) begin
              skip_nxt = skip_r + 2'd1;
            end
            cnt_nxt = cnt_inc;
          end
        end
        CMD_EOL: begin
          if (mode == MODE_LINE) begin
            res.valid   = 1'b1;
            res.matched = found_r;
            res.kind    = KIND_LINE;
            res.length  = cnt_r;
            pmv_nxt     = '0;
            found_nxt   = 1'b0;
            wpos_nxt    = '0;
            skip_nxt    = '0;
            cnt_nxt     = '0;
          end else if (cnt_r != '0) begin
            res.valid   = 1'b1;
            res.matched = (wpos_r == eff_len) && (skip_r < SKIP_SAT);
            res.kind    = KIND_WORD;
            res.length  = cnt_r;
            wpos_nxt    = '0;
            skip_nxt    = '0;
            cnt_nxt     = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      pmv_r   <= '0;
      found_r <= 1'b0;
      wpos_r  <= '0;
      skip_r  <= '0;
      cnt_r   <= '0;
    end else begin
      pmv_r   <= pmv_nxt;
      found_r <= found_nxt;
      wpos_r  <= wpos_nxt;
      skip_r  <= skip_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/keyword_line_and_word_matcher.sv =====
// ----------------------------------------------------------------------------
// keyword_line_and_word_matcher
// Key search over a text byte stream, per line or per word.
// ----------------------------------------------------------------------------
// One request is taken every cycle while the result register is free or being
// taken; a request goes from the input register through one pass of compare
// and progress update into the result register, and it is held in the input
// register only while the result register waits.
// The rate is set by the update of the progress registers, which every text
// byte reads and writes. Key bytes are written by key requests and are
// undefined until written; writes to the mode or key length register clear
// all line and word progress.
`timescale 1ns / 1ps
`default_nettype none
`include "keyword_line_and_word_matcher_assert.svh"

module keyword_line_and_word_matcher
  import kwm_pkg::*;
#(
  parameter int KEY_MAX = KEY_MAX_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic [CMD_W-1:0]      in_command,
  input  wire logic [KIDX_W-1:0]     in_key_index,
  input  wire logic [BYTE_W-1:0]     in_data_byte,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic                  out_matched,
  output      logic                  out_unit_kind,
  output      logic [CNT_W-1:0]      out_unit_length,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(KEY_MAX);
  localparam int LEN_W = $clog2(KEY_MAX + 1);

  // input register
  logic              s1_valid_r;
  logic [CMD_W-1:0]  s1_cmd_r;
  logic [KIDX_W-1:0] s1_idx_r;
  logic [BYTE_W-1:0] s1_byte_r;

  // configuration
  logic               mode_r;
  logic [LEN_W-1:0]   eff_len_r;
  logic [KEY_MAX-1:0] len_mask_r;
  logic [KEY_MAX-1:0] len_top_r;
  logic [LEN_W-1:0]   eff_len_nxt;
  logic               cfg_clear;

  // result register
  logic             out_valid_r;
  logic             out_matched_r;
  logic             out_kind_r;
  logic [CNT_W-1:0] out_len_r;

  logic               step;
  logic               key_wr;
  logic [IDX_W-1:0]   key_addr;
  logic [KEY_MAX-1:0] eq;
  res_t               res;

  assign step     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r  <= in_command;
      s1_idx_r  <= in_key_index;
      s1_byte_r <= in_data_byte;
    end
  end

  // key length clamped to 1..KEY_MAX
  always_comb begin
    if (cfg_data == '0) begin
      eff_len_nxt = LEN_W'(1);
    end else if (32'(cfg_data) > 32'(KEY_MAX)) begin
      eff_len_nxt = LEN_W'(KEY_MAX);
    end else begin
      eff_len_nxt = LEN_W'(cfg_data);
    end
  end

  assign cfg_clear = cfg_we && ((cfg_index == CFG_MODE) || (cfg_index == CFG_KEYLEN));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_LINE;
      eff_len_r  <= LEN_W'(1);
      len_mask_r <= KEY_MAX'(1);
      len_top_r  <= KEY_MAX'(1);
    end else if (cfg_we) begin
      if (cfg_index == CFG_MODE) begin
        mode_r <= cfg_data[0];
      end else if (cfg_index == CFG_KEYLEN) begin
        eff_len_r <= eff_len_nxt;
        for (int i = 0; i < KEY_MAX; i++) begin
          len_mask_r[i] <= (32'(i) < 32'(eff_len_nxt));
          len_top_r[i]  <= (32'(i) + 32'd1 == 32'(eff_len_nxt));
        end
      end
    end
  end

  assign key_wr   = step && (s1_cmd_r == CMD_KEY) && (32'(s1_idx_r) < 32'(KEY_MAX));
  assign key_addr = IDX_W'(s1_idx_r);

  kwm_key_store #(
    .KEY_MAX (KEY_MAX)
  ) u_key_store (
    .clk      (clk),
    .wr_en    (key_wr),
    .wr_addr  (key_addr),
    .wr_data  (s1_byte_r),
    .cmp_byte (s1_byte_r),
    .eq       (eq)
  );

  kwm_matcher #(
    .KEY_MAX (KEY_MAX)
  ) u_matcher (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .clear     (cfg_clear),
    .cmd       (s1_cmd_r),
    .data_byte (s1_byte_r),
    .eq        (eq),
    .mode      (mode_r),
    .eff_len   (eff_len_r),
    .len_mask  (len_mask_r),
    .len_top   (len_top_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= res.valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      out_matched_r <= res.matched;
      out_kind_r    <= res.kind;
      out_len_r     <= res.length;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_matched     = out_matched_r;
  assign out_unit_kind   = out_kind_r;
  assign out_unit_length = out_len_r;

  `KWM_ASSERT_IMPL(a_ready_when_out_free, clk, rst_n, !out_valid_r, in_ready)
  `KWM_ASSERT_NEXT(a_line_end_gives_result, clk, rst_n, step && (s1_cmd_r == CMD_EOL) && (mode_r == MODE_LINE), out_valid_r && (out_kind_r == KIND_LINE))
  `KWM_ASSERT_IMPL(a_word_not_empty, clk, rst_n, out_valid_r && (out_kind_r == KIND_WORD), out_len_r != '0)
  `KWM_ASSERT_NEXT(a_key_write_no_result, clk, rst_n, step && (s1_cmd_r == CMD_KEY), !out_valid_r)

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Keyword line and word matcher testbench
// Drives key writes, text bytes and line ends under random valid/ready idling
// and register settings, predicts every line and word result from a private
// copy of the key and match progress, and checks results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import kwm_pkg::*;

typedef struct packed {
  logic             matched;
  logic             kind;
  logic [CNT_W-1:0] length;
} unit_result_t;

// Predicts line and word results and holds those still to come out.
class unit_scoreboard;
  logic [BYTE_W-1:0]    key_bytes [KEY_MAX_DEF];
  bit [KEY_MAX_DEF-1:0] prefix_hits;
  bit                   line_hit;
  bit [KLEN_W-1:0]      word_pos;
  bit [1:0]             word_skips;
  bit [CNT_W-1:0]       unit_len;
  bit                   mode;
  bit [KLEN_W-1:0]      key_len_reg;
  unit_result_t         expected_units[$];
  int                   failures;

  function new();
    mode = MODE_LINE;
    key_len_reg = KLEN_W'(1);
    failures = 0;
    clear_progress();
  endfunction

  function void clear_progress();
    prefix_hits = '0;
    line_hit = 1'b0;
    word_pos = '0;
    word_skips = '0;
    unit_len = '0;
  endfunction

  function int active_len();
    if (key_len_reg == 0) return 1;
    if (key_len_reg > KEY_MAX_DEF) return KEY_MAX_DEF;
    return int'(key_len_reg);
  endfunction

  function void count_byte();
    if (unit_len != CNT_SAT) unit_len++;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_MODE) begin
      mode = data[0];
      clear_progress();
    end else if (idx == CFG_KEYLEN) begin
      key_len_reg = data;
      clear_progress();
    end
  endfunction

  function void close_word();
    unit_result_t r;
    if (unit_len == 0) return;
    r.matched = (word_pos == active_len() && word_skips <= 1);
    r.kind = KIND_WORD;
    r.length = unit_len;
    expected_units.push_back(r);
    word_pos = '0;
    word_skips = '0;
    unit_len = '0;
  endfunction

  function void note_request(logic [CMD_W-1:0] cmd, logic [KIDX_W-1:0] idx,
                             logic [BYTE_W-1:0] b);
    int len;
    bit [KEY_MAX_DEF-1:0] eq;
    unit_result_t r;
    len = active_len();
    eq = '0;
    case (cmd)
      CMD_KEY: begin
        if (idx < KEY_MAX_DEF) key_bytes[idx] = b;
      end
      CMD_TEXT: begin
        if (mode == MODE_LINE) begin
          // every key position within the key length is compared in parallel
          for (int i = 0; i < len; i++)
            if (key_bytes[i] == b) eq[i] = 1'b1;
          prefix_hits = ((prefix_hits << 1) | KEY_MAX_DEF'(1)) & eq;
          if (prefix_hits[len-1]) line_hit = 1'b1;
          count_byte();
        end else if (b == CH_SPACE || b == CH_NEWLINE) begin
          close_word();
        end else begin
          if (word_pos < len && key_bytes[word_pos] == b) word_pos++;
          else if (word_skips < SKIP_SAT) word_skips++;
          count_byte();
        end
      end
      CMD_EOL: begin
        if (mode == MODE_LINE) begin
          r.matched = line_hit;
          r.kind = KIND_LINE;
          r.length = unit_len;
          expected_units.push_back(r);
          clear_progress();
        end else begin
          close_word();
        end
      end
      default: ;
    endcase
  endfunction

  function void check_unit(logic m, logic k, logic [CNT_W-1:0] l);
    unit_result_t want;
    if (expected_units.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected result: matched %0d kind %0d length %0d", m, k, l);
      return;
    end
    want = expected_units.pop_front();
    if (want.matched !== m || want.kind !== k || want.length !== l) begin
      failures++;
      if (failures <= 10)
        $display("mismatch: expected matched %0d kind %0d length %0d, got %0d %0d %0d",
                 want.matched, want.kind, want.length, m, k, l);
    end
  endfunction

  function int pending();
    return expected_units.size();
  endfunction

  function void flush_leftovers();
    if (expected_units.size() != 0) begin
      failures += expected_units.size();
      $display("%0d expected results never arrived", expected_units.size());
    end
  endfunction
endclass

module tb;
  localparam int CLK_HALF = 2;
  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD = 400;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef enum int {V_EXACT, V_INSERT1, V_INSERT2, V_DROP, V_SWAP, V_OTHER} shape_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      in_command = CMD_KEY;
  logic [KIDX_W-1:0]     in_key_index = '0;
  logic [BYTE_W-1:0]     in_data_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_matched;
  logic                  out_unit_kind;
  logic [CNT_W-1:0]      out_unit_length;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  unit_scoreboard sb;
  logic [BYTE_W-1:0] key_image [KEY_MAX_DEF];
  int key_len_now = 1;
  int sent_items = 0;
  int idle_cycles = 0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;
  bit long_hold_req = 1'b0;

  keyword_line_and_word_matcher uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_key_index    (in_key_index),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_matched     (out_matched),
    .out_unit_kind   (out_unit_kind),
    .out_unit_length (out_unit_length),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // ends the run when neither channel nor the config port moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic logic [BYTE_W-1:0] alpha_byte();
    return BYTE_W'("a" + $urandom_range(0, 2));
  endfunction

  function automatic logic [BYTE_W-1:0] sep_byte();
    return $urandom_range(0, 1) ? CH_SPACE : CH_NEWLINE;
  endfunction

  function automatic logic [BYTE_W-1:0] word_byte();
    logic [BYTE_W-1:0] b;
    if ($urandom_range(0, 99) < 80) return alpha_byte();
    do b = BYTE_W'($urandom_range(0, 255)); while (b == CH_SPACE || b == CH_NEWLINE);
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return alpha_byte();
    if (r < 75) return sep_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic send_request(logic [CMD_W-1:0] cmd, logic [KIDX_W-1:0] idx,
                              logic [BYTE_W-1:0] b);
    int gap;
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_key_index <= idx;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_request(cmd, idx, b);
    sent_items++;
  endtask

  task automatic put_key_byte(int idx, logic [BYTE_W-1:0] b);
    key_image[idx] = b;
    send_request(CMD_KEY, KIDX_W'(idx), b);
  endtask

  task automatic put_text(logic [BYTE_W-1:0] b);
    send_request(CMD_TEXT, KIDX_W'($urandom_range(0, 31)), b);
  endtask

  task automatic put_eol();
    send_request(CMD_EOL, KIDX_W'($urandom_range(0, 31)), BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic put_noise();
    send_request(CMD_UNUSED, KIDX_W'($urandom_range(0, 31)), BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic put_string(string s);
    for (int i = 0; i < s.len(); i++) put_text(s[i]);
  endtask

  // waits out every expected result and the pipeline behind it
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_KEYLEN)
      key_len_now = (data == 0) ? 1 : (data > KEY_MAX_DEF) ? KEY_MAX_DEF : int'(data);
  endtask

  // the key, or a near copy of it, as text bytes
  task automatic put_shaped(shape_t shape);
    int len, ins_a, ins_b, drop_at, swap_at;
    logic [BYTE_W-1:0] b;
    len = key_len_now;
    ins_a = $urandom_range(0, len);
    ins_b = $urandom_range(0, len);
    drop_at = $urandom_range(0, len - 1);
    swap_at = $urandom_range(0, len - 1);
    if (shape == V_OTHER) begin
      repeat ($urandom_range(1, 8)) put_text(word_byte());
      return;
    end
    for (int i = 0; i <= len; i++) begin
      if ((shape == V_INSERT1 || shape == V_INSERT2) && i == ins_a) put_text(word_byte());
      if (shape == V_INSERT2 && i == ins_b) put_text(word_byte());
      if (i < len && !(shape == V_DROP && i == drop_at)) begin
        b = key_image[i];
        if (shape == V_SWAP && i == swap_at) b = word_byte();
        put_text(b);
      end
    end
  endtask

  task automatic put_line(bit long_one);
    int n, at;
    bit plant;
    shape_t shape;
    n = long_one ? 270 : $urandom_range(0, 20);
    at = $urandom_range(0, n);
    plant = long_one || ($urandom_range(0, 2) != 0);
    shape = long_one ? V_EXACT : shape_t'($urandom_range(0, 5));
    for (int p = 0; p <= n; p++) begin
      if (plant && p == at) put_shaped(shape);
      if (p < n) begin
        if ($urandom_range(0, 49) == 0) put_key_byte($urandom_range(0, 31), word_byte());
        else if ($urandom_range(0, 59) == 0) put_noise();
        put_text(text_byte());
      end
    end
    put_eol();
  endtask

  task automatic put_word_line(bit long_one);
    int words, seps;
    words = $urandom_range(1, 5);
    if ($urandom_range(0, 5) == 0) put_text(sep_byte());
    for (int w = 0; w < words; w++) begin
      seps = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
      if (w > 0) repeat (seps) put_text(sep_byte());
      if (long_one && w == 0) repeat (270) put_text(word_byte());
      else put_shaped(shape_t'($urandom_range(0, 5)));
      if ($urandom_range(0, 39) == 0) put_key_byte($urandom_range(0, 31), word_byte());
      if ($urandom_range(0, 59) == 0) put_noise();
    end
    if ($urandom_range(0, 1)) put_text(sep_byte());
    put_eol();
    if ($urandom_range(0, 7) == 0) put_eol();
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] mode_data, logic [CFG_DATA_W-1:0] len_data,
                           int items, bit long_one, bit hold);
    int stop_at;
    if ($urandom_range(0, 1))
      set_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
              CFG_DATA_W'($urandom_range(0, 63)));
    set_reg(CFG_MODE, mode_data);
    set_reg(CFG_KEYLEN, len_data);
    for (int i = 0; i < key_len_now; i++) put_key_byte(i, word_byte());
    if (hold) long_hold_req = 1'b1;
    stop_at = sent_items + items;
    if (long_one) begin
      if (mode_data[0] == MODE_WORD) put_word_line(1'b1);
      else put_line(1'b1);
    end
    while (sent_items < stop_at) begin
      if (mode_data[0] == MODE_WORD) put_word_line(1'b0);
      else put_line(1'b0);
    end
    // sometimes leave a unit open; the next mode or key length write drops it
    if ($urandom_range(0, 1)) repeat ($urandom_range(1, 4)) put_text(word_byte());
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = out_burst ? 0 : $urandom_range(0, 16);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_unit(out_matched, out_unit_kind, out_unit_length);
    end
  end

  initial begin
    logic [BYTE_W-1:0] kb;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // key "abca..." with both byte extremes near the top
    for (int i = 0; i < KEY_MAX_DEF; i++) begin
      kb = (i == KEY_MAX_DEF - 2) ? 8'h00 :
           (i == KEY_MAX_DEF - 1) ? 8'hFF : BYTE_W'("a" + (i % 3));
      put_key_byte(i, kb);
    end

    // line mode, reset key length of one
    put_string("a");
    put_eol();
    put_eol();                       // empty line still reports
    put_text(8'h00);
    put_text(8'hFF);
    put_text(CH_SPACE);
    put_text(CH_NEWLINE);
    put_eol();
    put_noise();
    set_reg(CFG_KEYLEN, 6'd4);
    put_string("aabca");             // hit needs the overlapping prefix
    put_eol();
    put_string("abcb a");
    put_eol();

    // word mode: exact, one insertion, two insertions, short, empty words
    set_reg(CFG_MODE, {5'b0, MODE_WORD});
    put_string(" abca  abxca\nabxxca ab");
    put_eol();
    put_eol();
    put_string("ab");
    set_reg(CFG_SPARE_A, 6'h3F);     // spare indexes keep the open word
    set_reg(CFG_SPARE_B, 6'h00);
    put_string("ca ");
    put_string("ab");
    set_reg(CFG_KEYLEN, 6'd4);       // real register write clears it
    put_string("ca");
    put_eol();

    run_phase(6'h00, 6'd3, 150, 1'b0, 1'b0);
    run_phase(6'h01, 6'd4, 200, 1'b0, 1'b1);
    run_phase(6'h3E, 6'd1, 80, 1'b0, 1'b0);
    run_phase(6'h3F, 6'd0, 80, 1'b0, 1'b0);
    run_phase(6'h00, 6'd32, 120, 1'b0, 1'b0);
    run_phase(6'h01, 6'd32, 120, 1'b0, 1'b0);
    run_phase(6'h00, 6'd63, 80, 1'b0, 1'b0);
    run_phase(6'h01, 6'd33, 80, 1'b0, 1'b0);
    run_phase(6'h00, 6'd6, 400, 1'b1, 1'b0);
    run_phase(6'h01, 6'd5, 400, 1'b1, 1'b0);

    settle();
    sb.flush_leftovers();
    if (sb.failures == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule

// ===== keyword_line_and_word_matcher.f =====
+incdir+rtl/core
rtl/core/kwm_pkg.sv
rtl/core/kwm_key_store.sv
rtl/core/kwm_matcher.sv
rtl/core/keyword_line_and_word_matcher.sv
tb/sv/tb.sv
